FILE: hw/rtl/bls_pkg.sv
// Shared constants for the bus latency spike tracker.
// No dependencies; imported by every module of the block.
package bls_pkg;

  // default widths of the millisecond and microsecond fields
  localparam int MS_WIDTH_DEF = 10;
  localparam int US_WIDTH_DEF = 20;

  localparam int US_PER_MS = 1000;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  // running average keeps 15/16 of the old latency
  localparam int AVG_SHIFT = 4;

  // configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_BASE_LATENCY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RISE_TOL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPIKE_BAND   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BASE_LEAD    = 3'd5;

  // register reset values
  localparam int RST_BASE_LATENCY = 2;
  localparam int RST_CLAMP        = 100;
  localparam int RST_RISE_TOL     = 2;
  localparam int RST_SPIKE_BAND   = 3;
  localparam int RST_CONFIRM      = 3;
  localparam int RST_BASE_LEAD    = 5;

endpackage

FILE: hw/rtl/bls_cfg.sv
// Configuration registers of the spike tracker behind an APB-style port.
// Depends on bls_pkg.
module bls_cfg #(
  parameter int MS_WIDTH = bls_pkg::MS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bls_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0]    prdata,
  output logic [MS_WIDTH-1:0]               base_latency_ms,
  output logic [MS_WIDTH-1:0]               clamp_ms,
  output logic [MS_WIDTH-1:0]               rise_tolerance_ms,
  output logic [MS_WIDTH-1:0]               spike_band_ms,
  output logic [bls_pkg::CNT_W-1:0]         confirm_samples,
  output logic [MS_WIDTH-1:0]               base_lead_ms,
  output logic [MS_WIDTH+9:0]               clamp_us
);
  import bls_pkg::*;

  localparam int LIM_W = MS_WIDTH + 10;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [MS_WIDTH-1:0]  wr_ms;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[APB_ADDR_W-1:2];
  assign wr_ms = pwdata[MS_WIDTH-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_latency_ms   <= MS_WIDTH'(RST_BASE_LATENCY);
      clamp_ms          <= MS_WIDTH'(RST_CLAMP);
      rise_tolerance_ms <= MS_WIDTH'(RST_RISE_TOL);
      spike_band_ms     <= MS_WIDTH'(RST_SPIKE_BAND);
      confirm_samples   <= CNT_W'(RST_CONFIRM);
      base_lead_ms      <= MS_WIDTH'(RST_BASE_LEAD);
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_LATENCY: base_latency_ms   <= wr_ms;
        REG_CLAMP:        clamp_ms          <= wr_ms;
        REG_RISE_TOL:     rise_tolerance_ms <= wr_ms;
        REG_SPIKE_BAND:   spike_band_ms     <= wr_ms;
        REG_CONFIRM:      confirm_samples   <= pwdata[CNT_W-1:0];
        REG_BASE_LEAD:    base_lead_ms      <= wr_ms;
        default: ;
      endcase
    end
  end

  // ceiling in microseconds, registered from clamp_ms in the cycle after it changes
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_us <= LIM_W'(RST_CLAMP * US_PER_MS);
    end else begin
      clamp_us <= LIM_W'(clamp_ms) * LIM_W'(US_PER_MS);
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BASE_LATENCY: prdata = APB_DATA_W'(base_latency_ms);
      REG_CLAMP:        prdata = APB_DATA_W'(clamp_ms);
      REG_RISE_TOL:     prdata = APB_DATA_W'(rise_tolerance_ms);
      REG_SPIKE_BAND:   prdata = APB_DATA_W'(spike_band_ms);
      REG_CONFIRM:      prdata = APB_DATA_W'(confirm_samples);
      REG_BASE_LEAD:    prdata = APB_DATA_W'(base_lead_ms);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bls_ms.sv
// Duration front end: microseconds to clamped milliseconds, rounded up.
// Three register stages; depends on bls_pkg.
module bls_ms #(
  parameter int MS_WIDTH = bls_pkg::MS_WIDTH_DEF,
  parameter int US_WIDTH = bls_pkg::US_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [US_WIDTH-1:0] duration_us,
  input  logic [MS_WIDTH-1:0] clamp_ms,
  input  logic [MS_WIDTH+9:0] clamp_us,
  output logic                ms_valid,
  output logic [MS_WIDTH-1:0] ms,
  output logic                taken
);
  import bls_pkg::*;

  // quotient of a US_WIDTH value by 1000 fits in US_WIDTH-9 bits
  localparam int Q_W   = US_WIDTH - 9;
  localparam int LIM_W = MS_WIDTH + 10;
  localparam int CMP_W = (LIM_W > US_WIDTH) ? LIM_W : US_WIDTH;
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << US_WIDTH) / 64'd1000);

  // stage 1: input register
  logic                v1;
  logic [US_WIDTH-1:0] dur1;

  // stage 2: estimated quotient
  logic                v2;
  logic [US_WIDTH-1:0] x2;
  logic [Q_W-1:0]      qhat2;
  logic                nz2;
  logic                big2;

  logic [US_WIDTH-1:0]     x1;
  logic [US_WIDTH+Q_W-1:0] prod1;
  logic                    big1;

  logic [US_WIDTH-1:0] rem2;
  logic [Q_W-1:0]      q2;
  logic [MS_WIDTH-1:0] ms2;

  // ceil(d/1000) = floor((d-1)/1000) + 1; reciprocal estimate is low by at most one
  assign x1    = dur1 - US_WIDTH'(1);
  assign prod1 = (US_WIDTH+Q_W)'(x1) * (US_WIDTH+Q_W)'(RECIP);
  assign big1  = CMP_W'(dur1) > CMP_W'(clamp_us);

  assign rem2 = x2 - US_WIDTH'(qhat2) * US_WIDTH'(US_PER_MS);
  assign q2   = (rem2 >= US_WIDTH'(US_PER_MS)) ? qhat2 + Q_W'(1) : qhat2;
  // below the ceiling the rounded value always fits the ms width
  assign ms2  = big2 ? clamp_ms : MS_WIDTH'(US_WIDTH'(q2) + US_WIDTH'(1));

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      ms_valid <= 1'b0;
    end else if (adv) begin
      v1       <= in_valid;
      v2       <= v1;
      ms_valid <= v2;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      dur1  <= duration_us;
      x2    <= x1;
      qhat2 <= prod1[US_WIDTH+Q_W-1:US_WIDTH];
      nz2   <= dur1 != '0;
      big2  <= big1;
      ms    <= ms2;
      taken <= nz2 && (ms2 != '0);
    end
  end

endmodule

FILE: hw/rtl/bls_track.sv
// Latency tracker state, spike confirmation and result register.
// Depends on bls_pkg.
module bls_track #(
  parameter int MS_WIDTH = bls_pkg::MS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        ms_valid,
  input  logic [MS_WIDTH-1:0]         ms,
  input  logic                        taken,
  input  logic [MS_WIDTH-1:0]         base_latency_ms,
  input  logic [MS_WIDTH-1:0]         rise_tolerance_ms,
  input  logic [MS_WIDTH-1:0]         spike_band_ms,
  input  logic [bls_pkg::CNT_W-1:0]   confirm_samples,
  input  logic [MS_WIDTH-1:0]         base_lead_ms,
  output logic                        out_valid,
  output logic [MS_WIDTH-1:0]         latency_ms,
  output logic [MS_WIDTH:0]           lead_ms,
  output logic [MS_WIDTH-1:0]         pending_ms,
  output logic [bls_pkg::CNT_W-1:0]   pending_count,
  output logic                        sample_taken
);
  import bls_pkg::*;

  localparam int ACC_W = MS_WIDTH + AVG_SHIFT;

  logic [MS_WIDTH-1:0] tracked;
  logic [MS_WIDTH-1:0] cand;
  logic [CNT_W-1:0]    cnt;

  logic [MS_WIDTH-1:0] tracked_next;
  logic [MS_WIDTH-1:0] cand_next;
  logic [CNT_W-1:0]    cnt_next;

  logic [ACC_W-1:0]    acc;
  logic [MS_WIDTH-1:0] avg;
  logic [MS_WIDTH-1:0] rise;
  logic [MS_WIDTH-1:0] band_lo;
  logic [MS_WIDTH:0]   band_hi;
  logic                miss;
  logic [MS_WIDTH-1:0] cand_max;
  logic [CNT_W-1:0]    cnt_inc;
  logic [MS_WIDTH-1:0] lat;
  logic [MS_WIDTH-1:0] obs;

  // 15/16 running average: (16*T - T + ms) / 16
  assign acc  = (ACC_W'(tracked) << AVG_SHIFT) - ACC_W'(tracked) + ACC_W'(ms);
  assign avg  = acc[ACC_W-1:AVG_SHIFT];
  assign rise = ms - tracked;

  // confirmation band around the candidate
  assign band_lo  = (cand > spike_band_ms) ? cand - spike_band_ms : '0;
  assign band_hi  = {1'b0, cand} + {1'b0, spike_band_ms};
  assign miss     = (cnt == '0) || (ms < band_lo) || ({1'b0, ms} > band_hi);
  assign cand_max = (ms > cand) ? ms : cand;
  assign cnt_inc  = (cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;

  // state update for a taken sample
  always_comb begin
    tracked_next = tracked;
    cand_next    = cand;
    cnt_next     = cnt;
    if (taken) begin
      priority if (ms <= tracked) begin
        tracked_next = (avg < base_latency_ms) ? base_latency_ms : avg;
        cand_next    = '0;
        cnt_next     = '0;
      end else if (rise <= rise_tolerance_ms) begin
        tracked_next = ms;
        cand_next    = '0;
        cnt_next     = '0;
      end else if (miss) begin
        cand_next = ms;
        cnt_next  = CNT_W'(1);
      end else if (cnt_inc >= confirm_samples) begin
        tracked_next = cand_max;
        cand_next    = '0;
        cnt_next     = '0;
      end else begin
        cand_next = cand_max;
        cnt_next  = cnt_inc;
      end
    end
  end

  // result fields from the updated state
  always_comb begin
    lat = (tracked_next < base_latency_ms) ? base_latency_ms : tracked_next;
    obs = (tracked_next > cand_next) ? tracked_next : cand_next;
    if (obs < base_latency_ms) begin
      obs = base_latency_ms;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked <= MS_WIDTH'(RST_BASE_LATENCY);
      cand    <= '0;
      cnt     <= '0;
    end else if (adv && ms_valid) begin
      tracked <= tracked_next;
      cand    <= cand_next;
      cnt     <= cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ms_valid) begin
      latency_ms    <= lat;
      lead_ms       <= {1'b0, base_lead_ms} + {1'b0, obs} - {1'b0, base_latency_ms};
      pending_ms    <= cand_next;
      pending_count <= cnt_next;
      sample_taken  <= taken;
    end
  end

endmodule

FILE: hw/rtl/bus_latency_spike_tracker.sv
// Top level of the bus latency spike tracker: stream ports and APB registers.
// Depends on bls_pkg, bls_cfg, bls_ms and bls_track.

// Takes one transfer duration (us) per item and returns one result item for
// each, in order. A new item is accepted every cycle while the result side
// keeps up; an item's result passes through the input register, the reciprocal
// multiply for the /1000, the remainder correction and clamp, and the tracker
// update into the result register. The whole pipeline holds while a result
// waits, and s_axis_tready drops only then. A zero duration, or a ceiling of
// zero, leaves the state alone and returns tuser low. Registers should only
// be written while no item is in flight; a write to clamp_ms reaches the
// microsecond ceiling in the cycle after the write.
module bus_latency_spike_tracker #(
  parameter int MS_WIDTH = bls_pkg::MS_WIDTH_DEF,
  parameter int US_WIDTH = bls_pkg::US_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((US_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS    = 3 * MS_WIDTH + 5,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_axis_tdata: duration_us
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_TDATA_W-1:0]          s_axis_tdata,
  // m_axis_tdata: latency_ms, lead_ms, pending_ms, pending_count
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_TDATA_W-1:0]         m_axis_tdata,
  // m_axis_tuser: sample_taken
  output logic                           m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bls_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bls_pkg::*;

  logic                adv;
  logic [MS_WIDTH-1:0] base_latency_ms;
  logic [MS_WIDTH-1:0] clamp_ms;
  logic [MS_WIDTH-1:0] rise_tolerance_ms;
  logic [MS_WIDTH-1:0] spike_band_ms;
  logic [CNT_W-1:0]    confirm_samples;
  logic [MS_WIDTH-1:0] base_lead_ms;
  logic [MS_WIDTH+9:0] clamp_us;

  logic                ms_valid;
  logic [MS_WIDTH-1:0] ms;
  logic                taken;

  logic [MS_WIDTH-1:0] latency_ms;
  logic [MS_WIDTH:0]   lead_ms;
  logic [MS_WIDTH-1:0] pending_ms;
  logic [CNT_W-1:0]    pending_count;

  // pipeline moves whenever the result register is free or being emptied
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign pready        = 1'b1;

  bls_cfg #(
    .MS_WIDTH (MS_WIDTH)
  ) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .base_latency_ms   (base_latency_ms),
    .clamp_ms          (clamp_ms),
    .rise_tolerance_ms (rise_tolerance_ms),
    .spike_band_ms     (spike_band_ms),
    .confirm_samples   (confirm_samples),
    .base_lead_ms      (base_lead_ms),
    .clamp_us          (clamp_us)
  );

  bls_ms #(
    .MS_WIDTH (MS_WIDTH),
    .US_WIDTH (US_WIDTH)
  ) u_ms (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (s_axis_tvalid),
    .duration_us (s_axis_tdata[US_WIDTH-1:0]),
    .clamp_ms    (clamp_ms),
    .clamp_us    (clamp_us),
    .ms_valid    (ms_valid),
    .ms          (ms),
    .taken       (taken)
  );

  bls_track #(
    .MS_WIDTH (MS_WIDTH)
  ) u_track (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .ms_valid          (ms_valid),
    .ms                (ms),
    .taken             (taken),
    .base_latency_ms   (base_latency_ms),
    .rise_tolerance_ms (rise_tolerance_ms),
    .spike_band_ms     (spike_band_ms),
    .confirm_samples   (confirm_samples),
    .base_lead_ms      (base_lead_ms),
    .out_valid         (m_axis_tvalid),
    .latency_ms        (latency_ms),
    .lead_ms           (lead_ms),
    .pending_ms        (pending_ms),
    .pending_count     (pending_count),
    .sample_taken      (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'({pending_count, pending_ms, lead_ms, latency_ms});

endmodule

FILE: hw/rtl/bls_checker.sv
// Port-level checks for the spike tracker, bound to the top level.
// Depends on bls_pkg and bus_latency_spike_tracker.
module bls_checker #(
  parameter int MS_WIDTH = bls_pkg::MS_WIDTH_DEF,
  localparam int OUT_BITS    = 3 * MS_WIDTH + 5,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [OUT_TDATA_W-1:0]         m_axis_tdata,
  input logic                           m_axis_tuser
);
  import bls_pkg::*;

  logic [MS_WIDTH-1:0] pend;
  logic [CNT_W-1:0]    pend_cnt;

  assign pend     = m_axis_tdata[3*MS_WIDTH:2*MS_WIDTH+1];
  assign pend_cnt = m_axis_tdata[3*MS_WIDTH+CNT_W:3*MS_WIDTH+1];

  // input side is never held off while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result waiting");

  // a candidate is reported exactly when its count is nonzero
  a_pending_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((pend_cnt == '0) == (pend == '0)))
    else $error("pending latency and count disagree");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind bus_latency_spike_tracker bls_checker #(
  .MS_WIDTH (MS_WIDTH)
) u_bls_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for bus_latency_spike_tracker: a directed table,
// then random spike sequences under several register settings and flow patterns.
// Depends on bls_pkg and the tracker RTL; an in-bench tracker model predicts results.
module tb_top;
  import bls_pkg::*;

  localparam int MSW = MS_WIDTH_DEF;
  localparam int IN_W = ((US_WIDTH_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((3 * MSW + 5 + 7) / 8) * 8;
  localparam int unsigned MS_MASK = (1 << MSW) - 1;
  localparam int unsigned CNT_MASK = (1 << CNT_W) - 1;
  localparam int unsigned MAX_MS_IN = 1048;  // largest ms for which every duration that rounds to it fits in 20 bits
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES = 7;
  localparam int HALF_PHASE = 75;

  // one report as seen on the result side, lowest field last
  typedef struct packed {
    logic           sample_taken;
    logic [CNT_W-1:0] pending_count;
    logic [MSW-1:0] pending_ms;
    logic [MSW:0]   lead_ms;
    logic [MSW-1:0] latency_ms;
  } track_out_t;

  // stimulus table row: a register write or a duration, optionally with a typed report
  typedef struct packed {
    logic                    is_cfg;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic [US_WIDTH_DEF-1:0] val;
    logic                    fixed;
    track_out_t              res;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // tracker model: configuration and state
  int unsigned cfg_base = RST_BASE_LATENCY;
  int unsigned cfg_clamp = RST_CLAMP;
  int unsigned cfg_rise = RST_RISE_TOL;
  int unsigned cfg_band = RST_SPIKE_BAND;
  int unsigned cfg_confirm = RST_CONFIRM;
  int unsigned cfg_lead = RST_BASE_LEAD;
  int unsigned tracked_ms = RST_BASE_LATENCY;
  int unsigned cand_ms = 0;
  int unsigned cand_cnt = 0;

  stim_row_t  duration_q[$];
  track_out_t expected_report_q[$];
  stim_row_t  dir_tab[$];
  track_out_t predicted_report;

  int n_durations = 0;
  int n_reports = 0;
  int n_taken = 0;
  int n_spikes_adopted = 0;
  int n_reg_writes = 0;
  int n_errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_tick = 0;
  int quiet_cycles = 0;
  int last_level = 10;
  bit tx_gappy = 1'b1;
  rx_mode_t rx_mode = RX_RANDOM;

  bus_latency_spike_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model update for one accepted duration; returns the report it causes
  function automatic track_out_t predict_track(input logic [US_WIDTH_DEF-1:0] dur);
    int unsigned ms;
    int unsigned avg;
    int unsigned lo;
    int unsigned hi;
    int unsigned obs;
    bit taken;
    track_out_t o;
    taken = 1'b0;
    ms = 0;
    if (dur != 0) begin
      ms = (int'(dur) + US_PER_MS - 1) / US_PER_MS;
      if (ms > cfg_clamp) ms = cfg_clamp;
    end
    if (ms != 0) begin
      taken = 1'b1;
      n_taken++;
      if (ms <= tracked_ms) begin
        // at or below: 15/16 running average, held at the floor
        avg = (tracked_ms * ((1 << AVG_SHIFT) - 1) + ms) >> AVG_SHIFT;
        tracked_ms = (avg < cfg_base ? cfg_base : avg) & MS_MASK;
        cand_ms = 0;
        cand_cnt = 0;
      end else if (ms - tracked_ms <= cfg_rise) begin
        tracked_ms = ms;
        cand_ms = 0;
        cand_cnt = 0;
      end else begin
        lo = cand_ms > cfg_band ? cand_ms - cfg_band : 0;
        hi = cand_ms + cfg_band;
        if (cand_cnt == 0 || ms < lo || ms > hi) begin
          cand_ms = ms;
          cand_cnt = 1;
        end else begin
          // repeat within the band: follow the highest, count, maybe adopt
          if (ms > cand_ms) cand_ms = ms;
          if (cand_cnt < CNT_MAX) cand_cnt++;
          if (cand_cnt >= cfg_confirm) begin
            tracked_ms = cand_ms;
            cand_ms = 0;
            cand_cnt = 0;
            n_spikes_adopted++;
          end
        end
      end
    end
    obs = tracked_ms > cand_ms ? tracked_ms : cand_ms;
    if (obs < cfg_base) obs = cfg_base;
    o.latency_ms = MSW'(tracked_ms < cfg_base ? cfg_base : tracked_ms);
    o.lead_ms = (MSW+1)'(cfg_lead + (obs - cfg_base));
    o.pending_ms = MSW'(cand_ms);
    o.pending_count = CNT_W'(cand_cnt);
    o.sample_taken = taken;
    return o;
  endfunction

  function automatic stim_row_t cfg_row(input logic [REG_IDX_W-1:0] idx, input int unsigned v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.val = US_WIDTH_DEF'(v);
    return r;
  endfunction

  function automatic stim_row_t dur_row(input int unsigned d);
    stim_row_t r;
    r = '0;
    r.val = US_WIDTH_DEF'(d);
    return r;
  endfunction

  function automatic stim_row_t dur_row_exp(input int unsigned d, input int unsigned lat,
                                            input int unsigned lead, input int unsigned pend,
                                            input int unsigned cnt, input bit tk);
    stim_row_t r;
    r = dur_row(d);
    r.fixed = 1'b1;
    r.res.latency_ms = MSW'(lat);
    r.res.lead_ms = (MSW+1)'(lead);
    r.res.pending_ms = MSW'(pend);
    r.res.pending_count = CNT_W'(cnt);
    r.res.sample_taken = tk;
    return r;
  endfunction

  // pick a low or high extreme now and then, else a typical value
  function automatic int unsigned pick_extreme(input int unsigned lo, input int unsigned hi,
                                               input int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return typical;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // register write: setup cycle, then access cycle; model follows the write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASE_LATENCY: cfg_base = v & MS_MASK;
      REG_CLAMP:        cfg_clamp = v & MS_MASK;
      REG_RISE_TOL:     cfg_rise = v & MS_MASK;
      REG_SPIKE_BAND:   cfg_band = v & MS_MASK;
      REG_CONFIRM:      cfg_confirm = v & CNT_MASK;
      REG_BASE_LEAD:    cfg_lead = v & MS_MASK;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // sender stops until every report is back, then lets the pipeline settle
  task automatic wait_idle();
    while (duration_q.size() != 0 || expected_report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a duration in us that rounds up to the given ms
  task automatic push_ms(input int m);
    int unsigned d;
    if (m < 1) m = 1;
    if (m > MAX_MS_IN) m = MAX_MS_IN;
    d = (m - 1) * US_PER_MS + $urandom_range(1, US_PER_MS);
    duration_q.push_back(dur_row(d));
  endtask

  task automatic load_random_config(input int phase);
    write_reg(REG_BASE_LATENCY, pick_extreme(0, MS_MASK, $urandom_range(0, 40)));
    write_reg(REG_CLAMP, pick_extreme(1, MS_MASK, $urandom_range(20, 300)));
    write_reg(REG_RISE_TOL, phase == 2 ? MS_MASK : pick_extreme(0, MS_MASK, $urandom_range(0, 10)));
    write_reg(REG_SPIKE_BAND, phase == 2 ? 0 : pick_extreme(0, MS_MASK, $urandom_range(0, 8)));
    write_reg(REG_CONFIRM, phase == 1 ? CNT_MAX : $urandom_range(0, CNT_MASK));
    write_reg(REG_BASE_LEAD, $urandom_range(0, MS_MASK));
  endtask

  // mostly spike runs around a level, plus decays, zeros and raw noise
  task automatic queue_samples(input int n_samples);
    int made;
    int kind;
    int level;
    int reps;
    int band_cap;
    made = 0;
    while (made < n_samples) begin
      kind = $urandom_range(0, 9);
      band_cap = cfg_band > 20 ? 20 : cfg_band;
      if (kind == 0) begin
        duration_q.push_back(dur_row(0));
      end else if (kind == 1) begin
        duration_q.push_back(dur_row($urandom_range(1, (1 << US_WIDTH_DEF) - 1)));
        made++;
      end else if (kind <= 3) begin
        reps = $urandom_range(1, 4);
        repeat (reps) push_ms($urandom_range(1, last_level));
        made += reps;
      end else begin
        level = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(1, MS_MASK);
        reps = $urandom_range(1, cfg_confirm + 2);
        repeat (reps) push_ms(level + $urandom_range(0, 2 * band_cap) - band_cap);
        last_level = level;
        made += reps;
      end
    end
  endtask

  // sender: bursts and gaps; the model runs on each accepted item
  always @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predicted_report = predict_track(duration_q[0].val);
      expected_report_q.push_back(duration_q[0].fixed ? duration_q[0].res : predicted_report);
      void'(duration_q.pop_front());
      n_durations++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gappy && burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(0, 6);
      end
      if (gap_left > 0 || duration_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(duration_q[0].val);
        if (burst_left > 0) burst_left--;
      end
    end
  end

  // receiver: compare each report with the oldest expectation, then set tready for the flow mode
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_report_q.size() == 0) begin
        $error("report with none expected: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        predicted_report = expected_report_q.pop_front();
        check_field("latency_ms", 16'(predicted_report.latency_ms),
                    16'(m_axis_tdata[MSW-1:0]));
        check_field("lead_ms", 16'(predicted_report.lead_ms), 16'(m_axis_tdata[2*MSW:MSW]));
        check_field("pending_ms", 16'(predicted_report.pending_ms),
                    16'(m_axis_tdata[3*MSW:2*MSW+1]));
        check_field("pending_count", 16'(predicted_report.pending_count),
                    16'(m_axis_tdata[3*MSW+CNT_W:3*MSW+1]));
        check_field("sample_taken", 16'(predicted_report.sample_taken), 16'(m_axis_tuser));
      end
      n_reports++;
    end
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) < 4);
      default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
    rx_tick++;
  end

  // watchdog: too long without any handshake or register access
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, rounding edges, spike confirm, ceiling of zero,
    // confirm count of zero, floor above tracked latency, register extremes
    dir_tab = '{
      dur_row_exp(0, 2, 5, 0, 0, 1'b0),
      dur_row_exp(1, 2, 5, 0, 0, 1'b1),
      dur_row_exp(1000, 2, 5, 0, 0, 1'b1),
      dur_row_exp(1001, 2, 5, 0, 0, 1'b1),
      dur_row_exp(4000, 4, 7, 0, 0, 1'b1),
      dur_row(20000),
      dur_row(22000),
      dur_row(19500),
      dur_row((1 << US_WIDTH_DEF) - 1),
      dur_row(50000),
      dur_row(5000),
      dur_row(999),
      cfg_row(REG_CLAMP, 0),
      dur_row(5000),
      dur_row((1 << US_WIDTH_DEF) - 1),
      cfg_row(REG_CLAMP, MS_MASK),
      cfg_row(REG_RISE_TOL, 0),
      cfg_row(REG_SPIKE_BAND, MS_MASK),
      cfg_row(REG_CONFIRM, 0),
      dur_row(30000),
      dur_row(25000),
      cfg_row(REG_BASE_LATENCY, MS_MASK),
      cfg_row(REG_BASE_LEAD, MS_MASK),
      dur_row_exp(0, MS_MASK, MS_MASK, 0, 0, 1'b0),
      dur_row(40000),
      dur_row(35000),
      cfg_row(REG_BASE_LATENCY, 0),
      cfg_row(REG_BASE_LEAD, 0),
      dur_row_exp(0, 40, 40, 0, 0, 1'b0),
      cfg_row(REG_BASE_LATENCY, RST_BASE_LATENCY),
      cfg_row(REG_CLAMP, RST_CLAMP),
      cfg_row(REG_RISE_TOL, RST_RISE_TOL),
      cfg_row(REG_SPIKE_BAND, RST_SPIKE_BAND),
      cfg_row(REG_CONFIRM, RST_CONFIRM),
      cfg_row(REG_BASE_LEAD, RST_BASE_LEAD)
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].val);
      end else begin
        duration_q.push_back(dir_tab[i]);
      end
    end
    wait_idle();

    // random phases; the first runs with no idling on either side
    for (int phase = 0; phase < N_PHASES; phase++) begin
      tx_gappy = (phase != 0);
      rx_mode = phase == 0 ? RX_OPEN : rx_mode_t'($urandom_range(0, 3));
      load_random_config(phase);
      queue_samples(HALF_PHASE);
      wait_idle();
      queue_samples(HALF_PHASE);
      wait_idle();
    end

    $display("Ran %0d durations through %0d register writes; %0d reports checked.",
             n_durations, n_reg_writes, n_reports);
    $display("Samples taken: %0d, spikes confirmed and adopted: %0d, mismatches: %0d.",
             n_taken, n_spikes_adopted, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_cfg.sv
hw/rtl/bls_ms.sv
hw/rtl/bls_track.sv
hw/rtl/bus_latency_spike_tracker.sv
hw/rtl/bls_checker.sv
dv/tb_top.sv
